// File: src/bvir_pkg.sv
package bvir_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // Fixed port widths
  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Internal widths that follow from capacity
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_FRONT  = 3'd6,
    OP_BACK   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // What each cell of the row does this cycle, relative to the target slot
  typedef enum logic [1:0] {
    CMD_IDLE,     // hold
    CMD_LOAD_AT,  // load value at target
    CMD_OPEN_AT,  // load value at target, cells above take left neighbor
    CMD_CLOSE_AT  // cells at and above target take right neighbor
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [IDX_W-1:0]       target;
    logic [IDX_W-1:0]       rd_idx;
    logic [DATA_WIDTH-1:0]  value;
  } bvir_cmd_t;

endpackage

// File: src/bounded_vector_insert_remove.sv
// done is registered: it rises in the cycle after start is accepted and strobes for one cycle per item.
// Throughput: 1 item per cycle while rst is low; every op finishes in one pass of the cell row.
// busy is high only while rst is asserted; the receiver cannot stall done.
// Reset: synchronous active-high rst clears the occupancy count and the done strobe;
// the entry cells are not cleared and hold no meaning until written.
module bounded_vector_insert_remove (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [bvir_pkg::OP_W-1:0]          op,
  input  logic [bvir_pkg::POS_W-1:0]         position,
  input  logic [bvir_pkg::VALUE_W-1:0]       item_value,
  output logic                               done,
  output logic [bvir_pkg::VALUE_W-1:0]       read_value,
  output logic [1:0]                         status,
  output logic [bvir_pkg::COUNT_W-1:0]       entry_count
);

  // Occupancy of the table
  logic [bvir_pkg::CNT_W-1:0] count;
  logic [bvir_pkg::CNT_W-1:0] count_next;

  // Broadcast to every cell of the row
  bvir_pkg::bvir_cmd_t cmd;

  // Row storage and per-cell read taps
  logic [bvir_pkg::DATA_WIDTH-1:0] cell_data [bvir_pkg::CAPACITY];
  logic [bvir_pkg::DATA_WIDTH-1:0] rd_part   [bvir_pkg::CAPACITY];
  logic [bvir_pkg::DATA_WIDTH-1:0] rd_bus;

  // Decode results for the item at the ports
  logic                          accept;
  logic [bvir_pkg::CMP_W-1:0]    pos_ext;
  logic [bvir_pkg::CMP_W-1:0]    count_ext;
  logic                          is_empty;
  logic                          is_full;
  logic                          is_read;
  bvir_pkg::status_t             st_next;
  logic [bvir_pkg::DATA_WIDTH-1:0] rd_value_next;

  assign busy    = rst;
  assign accept  = start && !busy;

  assign pos_ext   = bvir_pkg::CMP_W'(position);
  assign count_ext = bvir_pkg::CMP_W'(count);
  assign is_empty  = (count == '0);
  assign is_full   = (count == bvir_pkg::CNT_W'(bvir_pkg::CAPACITY));

  // Decode the op: pick status, new count and what the cell row does.
  // A failed op leaves the row idle and the count unchanged.
  always_comb begin
    cmd.kind   = bvir_pkg::CMD_IDLE;
    cmd.target = bvir_pkg::IDX_W'(position);
    cmd.rd_idx = bvir_pkg::IDX_W'(position);
    cmd.value  = bvir_pkg::DATA_WIDTH'(item_value);
    count_next = count;
    st_next    = bvir_pkg::ST_OK;
    is_read    = 1'b0;

    case (bvir_pkg::op_t'(op))
      bvir_pkg::OP_PUSH: begin
        if (is_full) begin
          st_next = bvir_pkg::ST_FULL;
        end else begin
          cmd.kind   = bvir_pkg::CMD_LOAD_AT;
          cmd.target = bvir_pkg::IDX_W'(count);
          count_next = count + 1'b1;
        end
      end
      bvir_pkg::OP_POP: begin
        if (is_empty) st_next = bvir_pkg::ST_EMPTY;
        else count_next = count - 1'b1;
      end
      bvir_pkg::OP_INSERT: begin
        // Range test comes before the full test
        if (pos_ext > count_ext) begin
          st_next = bvir_pkg::ST_RANGE;
        end else if (is_full) begin
          st_next = bvir_pkg::ST_FULL;
        end else begin
          cmd.kind   = bvir_pkg::CMD_OPEN_AT;
          count_next = count + 1'b1;
        end
      end
      bvir_pkg::OP_REMOVE: begin
        if (pos_ext >= count_ext) begin
          st_next = bvir_pkg::ST_RANGE;
        end else begin
          cmd.kind   = bvir_pkg::CMD_CLOSE_AT;
          count_next = count - 1'b1;
        end
      end
      bvir_pkg::OP_READ: begin
        if (pos_ext >= count_ext) st_next = bvir_pkg::ST_RANGE;
        else is_read = 1'b1;
      end
      bvir_pkg::OP_WRITE: begin
        if (pos_ext >= count_ext) st_next = bvir_pkg::ST_RANGE;
        else cmd.kind = bvir_pkg::CMD_LOAD_AT;
      end
      bvir_pkg::OP_FRONT: begin
        cmd.rd_idx = '0;
        if (is_empty) st_next = bvir_pkg::ST_EMPTY;
        else is_read = 1'b1;
      end
      bvir_pkg::OP_BACK: begin
        cmd.rd_idx = bvir_pkg::IDX_W'(count - 1'b1);
        if (is_empty) st_next = bvir_pkg::ST_EMPTY;
        else is_read = 1'b1;
      end
      default: st_next = bvir_pkg::ST_OK;
    endcase

    // Hold the row when no item is taken
    if (!accept) begin
      cmd.kind   = bvir_pkg::CMD_IDLE;
      count_next = count;
    end
  end

  // Row of cells: each neighbor hands its entry along on insert/remove.
  // The end cells see their own entry beyond the edge; that value is never read.
  for (genvar i = 0; i < bvir_pkg::CAPACITY; i++) begin : g_cell
    logic [bvir_pkg::DATA_WIDTH-1:0] left_in;
    logic [bvir_pkg::DATA_WIDTH-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = cell_data[i];
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end

    if (i == bvir_pkg::CAPACITY - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end

    bvir_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_index (bvir_pkg::IDX_W'(i)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .rd_data    (rd_part[i])
    );
  end

  // Combine the read taps: at most one cell drives a nonzero value
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < bvir_pkg::CAPACITY; k++) begin
      rd_bus = rd_bus | rd_part[k];
    end
  end

  // Read value is zero unless a read, front or back succeeds
  assign rd_value_next = is_read ? rd_bus : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result payload: advance on each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value  <= bvir_pkg::VALUE_W'(rd_value_next);
      status      <= st_next;
      entry_count <= bvir_pkg::COUNT_W'(count_next);
    end
  end

endmodule

// File: src/bvir_cell.sv
module bvir_cell (
  input  logic                            clk,
  input  bvir_pkg::bvir_cmd_t             cmd,
  input  logic [bvir_pkg::IDX_W-1:0]      cell_index,
  input  logic [bvir_pkg::DATA_WIDTH-1:0] left_data,
  input  logic [bvir_pkg::DATA_WIDTH-1:0] right_data,
  output logic [bvir_pkg::DATA_WIDTH-1:0] data,
  output logic [bvir_pkg::DATA_WIDTH-1:0] rd_data
);

  logic [bvir_pkg::DATA_WIDTH-1:0] data_next;
  logic                            at_target;
  logic                            above_target;

  assign at_target    = (cell_index == cmd.target);
  assign above_target = (cell_index > cmd.target);

  always_comb begin
    data_next = data;
    case (cmd.kind)
      bvir_pkg::CMD_LOAD_AT: begin
        if (at_target) data_next = cmd.value;
      end
      bvir_pkg::CMD_OPEN_AT: begin
        if (at_target) data_next = cmd.value;
        else if (above_target) data_next = left_data;
      end
      bvir_pkg::CMD_CLOSE_AT: begin
        if (at_target || above_target) data_next = right_data;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Drive the read bus only when selected
  assign rd_data = (cell_index == cmd.rd_idx) ? data : '0;

endmodule

// File: tb/testbench.sv
module testbench;
  import bvir_pkg::*;

  // Stop the run once this many cycles pass with no item taken and no result seen
  localparam int QUIET_LIMIT  = 500;
  localparam int RANDOM_ITEMS = 1600;

  // Expected outcome of one item
  typedef struct packed {
    logic [VALUE_W-1:0] rd;
    status_t            st;
    logic [COUNT_W-1:0] cnt;
  } vec_result_t;

  // Kind of random phase: grow toward full, shrink toward empty, or churn evenly
  typedef enum logic [1:0] {
    PH_GROW,
    PH_SHRINK,
    PH_CHURN
  } phase_t;

  // Tracks the vector contents and holds the results still owed by the block
  class vector_tracker;
    logic [DATA_WIDTH-1:0] cells [CAPACITY];
    int unsigned           fill;
    vec_result_t           pending_results [$];
    int unsigned           errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Apply one accepted item to the vector copy and queue its outcome
    function void note_op(op_t o, logic [POS_W-1:0] p, logic [VALUE_W-1:0] v);
      vec_result_t r;
      int unsigned pi;
      int unsigned i;
      r.rd = '0;
      r.st = ST_OK;
      pi   = p;
      case (o)
        OP_PUSH: begin
          if (fill >= CAPACITY) r.st = ST_FULL;
          else begin
            cells[fill] = v[DATA_WIDTH-1:0];
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) r.st = ST_EMPTY;
          else fill--;
        end
        OP_INSERT: begin
          if (pi > fill) r.st = ST_RANGE;
          else if (fill >= CAPACITY) r.st = ST_FULL;
          else begin
            for (i = fill; i > pi; i--) cells[i] = cells[i-1];
            cells[pi] = v[DATA_WIDTH-1:0];
            fill++;
          end
        end
        OP_REMOVE: begin
          if (pi >= fill) r.st = ST_RANGE;
          else begin
            for (i = pi; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        OP_READ: begin
          if (pi >= fill) r.st = ST_RANGE;
          else r.rd = VALUE_W'(cells[pi]);
        end
        OP_WRITE: begin
          if (pi >= fill) r.st = ST_RANGE;
          else cells[pi] = v[DATA_WIDTH-1:0];
        end
        OP_FRONT: begin
          if (fill == 0) r.st = ST_EMPTY;
          else r.rd = VALUE_W'(cells[0]);
        end
        default: begin
          if (fill == 0) r.st = ST_EMPTY;
          else r.rd = VALUE_W'(cells[fill-1]);
        end
      endcase
      r.cnt = COUNT_W'(fill);
      pending_results.push_back(r);
    endfunction

    // Compare one strobed result against the oldest outstanding outcome
    function void check_result(logic [VALUE_W-1:0] rd, logic [1:0] st,
                               logic [COUNT_W-1:0] cnt);
      vec_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: read_value %h status %0d count %0d",
                 $time, rd, st, cnt);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (rd !== e.rd) begin
        $display("%0t: read_value mismatch: expected %h actual %h", $time, e.rd, rd);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (cnt !== e.cnt) begin
        $display("%0t: entry_count mismatch: expected %0d actual %0d", $time, e.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      op;
  logic [POS_W-1:0]     position;
  logic [VALUE_W-1:0]   item_value;
  logic                 done;
  logic [VALUE_W-1:0]   read_value;
  logic [1:0]           status;
  logic [COUNT_W-1:0]   entry_count;

  vector_tracker tracker = new();
  int unsigned   burst_left = 0;
  int unsigned   quiet_cycles = 0;

  bounded_vector_insert_remove dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .position    (position),
    .item_value  (item_value),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every strobed result; values are sampled before this edge updates them
  always @(posedge clk) begin
    if (done === 1'b1) tracker.check_result(read_value, status, entry_count);
  end

  // Watchdog: count cycles in which neither an item nor a result moves
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drop start for a random gap at the end of each burst; long bursts give
  // stretches with back-to-back items
  task automatic pause_between_items();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Present one item, hold it until the block takes it, then note it
  task automatic issue(op_t o, logic [POS_W-1:0] p, logic [VALUE_W-1:0] v);
    start      <= 1'b1;
    op         <= o;
    position   <= p;
    item_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    tracker.note_op(o, p, v);
    pause_between_items();
  endtask

  // Favor positions near the live range so shifts and edge indexes get hit often
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return POS_W'($urandom_range(0, tracker.fill));
    if (r < 78) return POS_W'(tracker.fill);
    if (r < 85) return POS_W'((tracker.fill == 0) ? 0 : tracker.fill - 1);
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  function automatic op_t pick_op(phase_t ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (r < 45) return OP_PUSH;
        if (r < 80) return OP_INSERT;
      end
      PH_SHRINK: begin
        if (r < 40) return OP_POP;
        if (r < 80) return OP_REMOVE;
      end
      default: ;
    endcase
    return op_t'($urandom_range(0, 7));
  endfunction

  initial begin
    phase_t      ph;
    int unsigned phase_left;
    int unsigned n;

    rst        <= 1'b1;
    start      <= 1'b0;
    op         <= OP_PUSH;
    position   <= '0;
    item_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: every failure on an empty vector first
    issue(OP_POP,    7'd0,   32'h0);
    issue(OP_FRONT,  7'd0,   32'h0);
    issue(OP_BACK,   7'd0,   32'h0);
    issue(OP_REMOVE, 7'd0,   32'h0);
    issue(OP_READ,   7'd0,   32'h0);
    issue(OP_WRITE,  7'd0,   32'hFFFF_FFFF);
    issue(OP_INSERT, 7'd1,   32'h1111_1111);
    issue(OP_INSERT, 7'd127, 32'h2222_2222);
    // Build a small vector with extreme values, inserts at front, middle, end
    issue(OP_PUSH,   7'd0,   32'hFFFF_FFFF);
    issue(OP_PUSH,   7'd127, 32'h0000_0000);
    issue(OP_INSERT, 7'd0,   32'hA5A5_5A5A);
    issue(OP_INSERT, 7'd1,   32'h1234_5678);
    issue(OP_INSERT, 7'd4,   32'h8000_0001);
    // Reads at both ends and past the end
    issue(OP_READ,   7'd127, 32'h0);
    issue(OP_READ,   7'd5,   32'h0);
    issue(OP_READ,   7'd0,   32'h0);
    issue(OP_READ,   7'd4,   32'h0);
    issue(OP_WRITE,  7'd2,   32'hDEAD_BEEF);
    issue(OP_READ,   7'd2,   32'h0);
    // Remove from the middle, the last slot, and out of range
    issue(OP_REMOVE, 7'd1,   32'h0);
    issue(OP_REMOVE, 7'd3,   32'h0);
    issue(OP_REMOVE, 7'd64,  32'h0);
    issue(OP_FRONT,  7'd0,   32'h0);
    issue(OP_BACK,   7'd0,   32'h0);
    issue(OP_POP,    7'd0,   32'h0);

    // Random: grow toward capacity, shrink toward empty, then phases of random kind
    ph         = PH_GROW;
    phase_left = 200;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        if (n == 200) ph = PH_SHRINK;
        else ph = phase_t'($urandom_range(0, 2));
        phase_left = (n == 200) ? 200 : $urandom_range(30, 200);
      end
      phase_left--;
      issue(pick_op(ph), pick_position(), $urandom());
    end

    // Drain: wait for every outstanding result before reporting
    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
